FILE: rtl/dpvf_pkg.sv
`default_nettype none

package dpvf_pkg;

    localparam int ACC_WIDTH  = 32;

    localparam int E_W        = 16;
    localparam int G_W        = 16;
    localparam int DT_W       = 16;
    localparam int OUT_W      = 32;

    localparam int MUL_A_W    = 2 * G_W + 1;
    localparam int MUL_B_W    = E_W + 2;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int I_SHIFT    = 17;
    localparam int D_SHIFT    = 16;

    localparam int DIV_W      = MUL_A_W + D_SHIFT;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int DELTA_W    = DIV_W + 3;
    localparam int SUM_W      = ((ACC_WIDTH > DELTA_W) ? ACC_WIDTH : DELTA_W) + 1;

    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_KP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KI = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KD = 2'd2;

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] MS_P     = 3'd0;
    localparam logic [STEP_W-1:0] MS_KIDT  = 3'd1;
    localparam logic [STEP_W-1:0] MS_I     = 3'd2;
    localparam logic [STEP_W-1:0] MS_D     = 3'd3;
    localparam logic [STEP_W-1:0] MS_DIVLD = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_ADD  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/discrete_pid_velocity_form.sv
// Velocity-form PID step: one shared signed multiplier and a radix-2 divider under a sequencer.
// A step result passes through S_MUL, S_DIV, S_ADD and S_FIN; a clear goes from S_IDLE straight to S_FIN.
// The input accepts an item only in S_IDLE, so a step finishes its bit-serial divide by dt before the next is taken.
// A waiting result sits in the output register while the next item is taken.
// Synchronous active-low reset zeroes gains, error history and previous control value.
`default_nettype none

module discrete_pid_velocity_form (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [dpvf_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire [dpvf_pkg::G_W-1:0]             i_cfg_wdata,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire [dpvf_pkg::E_W+dpvf_pkg::DT_W-1:0] i_s_axis_tdata,  // error_sample, sample_period
    input  wire                                 i_s_axis_tuser,  // cmd
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    output logic [dpvf_pkg::OUT_W-1:0]          o_m_axis_tdata,  // control_value
    output logic                                o_m_axis_tuser   // saturated
);
    import dpvf_pkg::*;

    localparam logic signed [PROD_W-1:0] I_BIAS = PROD_W'((1 << I_SHIFT) - 1);
    localparam logic signed [SUM_W-1:0] ACC_HI =
        {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_LO = ~ACC_HI;
    localparam logic signed [SUM_W-1:0] OUT_HI =
        {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] OUT_LO = ~OUT_HI;

    t_state                        r_state;
    logic [STEP_W-1:0]             r_step;
    logic [DIV_CNT_W-1:0]          r_cnt;
    logic [G_W-1:0]                r_kp, r_ki, r_kd;
    logic                          r_cmd;
    logic signed [E_W-1:0]         r_e, r_e1, r_e2;
    logic [DT_W-1:0]               r_dt;
    logic signed [ACC_WIDTH-1:0]   r_prev;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [DELTA_W-1:0]     r_acc;
    logic [DIV_W-1:0]              r_quo;
    logic [DT_W-1:0]               r_rem;
    logic                          r_neg;
    logic                          r_out_valid;
    logic [OUT_W-1:0]              r_out_data;
    logic                          r_out_sat;

    logic signed [MUL_A_W-1:0]     w_mul_a;
    logic signed [MUL_B_W-1:0]     w_mul_b;
    logic signed [PROD_W-1:0]      w_prod;
    logic signed [PROD_W-1:0]      w_ibiased;
    logic signed [PROD_W-1:0]      w_iterm;
    logic [PROD_W-1:0]             w_pmag;
    logic [DT_W:0]                 w_shift;
    logic [DT_W+1:0]               w_diff;
    logic [DELTA_W-1:0]            w_qext;
    logic [DELTA_W-1:0]            w_dterm;
    logic signed [SUM_W-1:0]       w_sum;
    logic signed [SUM_W-1:0]       w_acc_val;
    logic signed [SUM_W-1:0]       w_out_val;
    logic                          w_acc_sat;
    logic                          w_out_clip;
    logic                          w_out_free;
    logic                          w_in_xfer;
    logic [DT_W-1:0]               w_in_dt;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_dt         = (i_s_axis_tdata[E_W+DT_W-1:E_W] == '0) ? DT_W'(1)
                                                                   : i_s_axis_tdata[E_W+DT_W-1:E_W];
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    always_comb begin
        unique case (r_step)
            MS_P: begin
                w_mul_a = $signed(MUL_A_W'(r_kp));
                w_mul_b = MUL_B_W'(r_e) - MUL_B_W'(r_e1);
            end
            MS_KIDT: begin
                w_mul_a = $signed(MUL_A_W'(r_ki));
                w_mul_b = $signed(MUL_B_W'(r_dt));
            end
            MS_I: begin
                w_mul_a = r_prod[MUL_A_W-1:0];
                w_mul_b = MUL_B_W'(r_e) + MUL_B_W'(r_e1);
            end
            MS_D: begin
                w_mul_a = $signed(MUL_A_W'(r_kd));
                w_mul_b = MUL_B_W'(r_e) - (MUL_B_W'(r_e1) <<< 1) + MUL_B_W'(r_e2);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod    = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_ibiased = r_prod + (r_prod[PROD_W-1] ? I_BIAS : '0);
    assign w_iterm   = w_ibiased >>> I_SHIFT;
    assign w_pmag    = r_prod[PROD_W-1] ? -r_prod : r_prod;

    assign w_shift   = {r_rem, r_quo[DIV_W-1]};
    assign w_diff    = {1'b0, w_shift} - {2'b0, r_dt};

    assign w_qext    = DELTA_W'(r_quo);
    assign w_dterm   = r_neg ? -w_qext : w_qext;

    assign w_sum      = SUM_W'(r_prev) + SUM_W'(r_acc);
    assign w_acc_sat  = (w_sum > ACC_HI) || (w_sum < ACC_LO);
    assign w_acc_val  = (w_sum > ACC_HI) ? ACC_HI : ((w_sum < ACC_LO) ? ACC_LO : w_sum);
    assign w_out_clip = (w_acc_val > OUT_HI) || (w_acc_val < OUT_LO);
    assign w_out_val  = (w_acc_val > OUT_HI) ? OUT_HI
                      : ((w_acc_val < OUT_LO) ? OUT_LO : w_acc_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_ki <= '0;
            r_kd <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_KP:  r_kp <= i_cfg_wdata;
                REG_KI:  r_ki <= i_cfg_wdata;
                REG_KD:  r_kd <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= MS_P;
            r_cnt       <= '0;
            r_e1        <= '0;
            r_e2        <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_cmd  <= i_s_axis_tuser;
                        r_e    <= $signed(i_s_axis_tdata[E_W-1:0]);
                        r_dt   <= w_in_dt;
                        r_step <= MS_P;
                        r_state <= (i_s_axis_tuser == CMD_CLEAR) ? S_FIN : S_MUL;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + STEP_W'(1);
                    unique case (r_step)
                        MS_P: begin
                            r_prod <= w_prod;
                        end
                        MS_KIDT: begin
                            r_acc  <= DELTA_W'(r_prod);
                            r_prod <= w_prod;
                        end
                        MS_I: begin
                            r_prod <= w_prod;
                        end
                        MS_D: begin
                            r_acc  <= r_acc + DELTA_W'(w_iterm);
                            r_prod <= w_prod;
                        end
                        default: begin
                            r_quo   <= {w_pmag[MUL_A_W-1:0], D_SHIFT'(0)};
                            r_neg   <= r_prod[PROD_W-1];
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    endcase
                end
                S_DIV: begin
                    if (!w_diff[DT_W+1]) begin
                        r_rem <= w_diff[DT_W-1:0];
                        r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_shift[DT_W-1:0];
                        r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_acc   <= r_acc + $signed(w_dterm);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        if (r_cmd == CMD_CLEAR) begin
                            r_prev     <= '0;
                            r_e1       <= '0;
                            r_e2       <= '0;
                            r_out_data <= '0;
                            r_out_sat  <= 1'b0;
                        end else begin
                            r_prev     <= ACC_WIDTH'(w_acc_val);
                            r_e2       <= r_e1;
                            r_e1       <= r_e;
                            r_out_data <= OUT_W'(w_out_val);
                            r_out_sat  <= w_acc_sat || w_out_clip;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sat;

    a_rem_below_dt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dt))
        else $error("divider remainder not below sample period");

    a_dt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_DIV) |-> (r_dt != '0))
        else $error("zero sample period reached the divider");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        (o_m_axis_tdata == OUT_W'(OUT_HI) || o_m_axis_tdata == OUT_W'(OUT_LO)))
        else $error("saturated flag without limit value");

    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !w_out_free) |=> (r_state == S_FIN))
        else $error("result dropped while output register was full");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dpvf_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RESULT_LATENCY = 60;

    typedef struct {
        logic signed [OUT_W-1:0] control_value;
        logic                    saturated;
    } t_pid_output;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]    i_cfg_addr = '0;
    logic [G_W-1:0]           i_cfg_wdata = '0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [E_W+DT_W-1:0]      i_s_axis_tdata = '0;  // error_sample, sample_period
    logic                     i_s_axis_tuser = 1'b0;  // cmd
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]         o_m_axis_tdata;  // control_value
    logic                     o_m_axis_tuser;  // saturated

    // controller state mirrored by the predictor
    longint      gain_p = 0;
    longint      gain_i = 0;
    longint      gain_d = 0;
    longint      prev_control = 0;
    longint      err_last = 0;
    longint      err_before_last = 0;

    t_pid_output expected_outputs[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;
    int          stall_left = 0;

    discrete_pid_velocity_form u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[discrete_pid_velocity_form] ERROR");
            $finish;
        end
    end

    function automatic t_pid_output pid_step(logic cmd, logic signed [E_W-1:0] err_in,
                                             logic [DT_W-1:0] period_in);
        longint      e;
        longint      dt;
        longint      p_term;
        longint      i_term;
        longint      d_term;
        longint      delta;
        longint      sum;
        longint      acc_hi;
        longint      acc_lo;
        t_pid_output r;
        r.control_value = '0;
        r.saturated = 1'b0;
        if (cmd == CMD_CLEAR) begin
            prev_control = 0;
            err_last = 0;
            err_before_last = 0;
            return r;
        end
        e = longint'(err_in);
        dt = longint'(period_in);
        if (dt == 0) dt = 1;
        acc_hi = longint'((64'd1 << (ACC_WIDTH - 1)) - 64'd1);
        acc_lo = -acc_hi - 1;
        p_term = gain_p * (e - err_last);
        i_term = (gain_i * dt * (e + err_last)) / 131072;
        d_term = (gain_d * 65536 * (e - 2 * err_last + err_before_last)) / dt;
        delta = p_term + i_term + d_term;
        if (delta > 0 && prev_control > acc_hi - delta) begin
            sum = acc_hi;
            r.saturated = 1'b1;
        end else if (delta < 0 && prev_control < acc_lo - delta) begin
            sum = acc_lo;
            r.saturated = 1'b1;
        end else begin
            sum = prev_control + delta;
        end
        prev_control = sum;
        err_before_last = err_last;
        err_last = e;
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            r.saturated = 1'b1;
        end
        if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            r.saturated = 1'b1;
        end
        r.control_value = sum[OUT_W-1:0];
        return r;
    endfunction

    // output side: random stalls (none while no_idle is set), compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_pid_output want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_outputs.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d sat %0b",
                         $time, $signed(o_m_axis_tdata), o_m_axis_tuser);
                error_count++;
            end else begin
                want = expected_outputs.pop_front();
                if (o_m_axis_tdata !== want.control_value) begin
                    $display("%0t: control_value expected %0d actual %0d", $time,
                             want.control_value, $signed(o_m_axis_tdata));
                    error_count++;
                end
                if (o_m_axis_tuser !== want.saturated) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             want.saturated, o_m_axis_tuser);
                    error_count++;
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 10);
        end
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(logic cmd, logic signed [E_W-1:0] err_in, logic [DT_W-1:0] period_in);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {period_in, err_in};
        i_s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_outputs.push_back(pid_step(cmd, err_in, period_in));
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_outputs.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [G_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (addr)
            REG_KP: gain_p = longint'(data);
            REG_KI: gain_i = longint'(data);
            REG_KD: gain_d = longint'(data);
            default: ;
        endcase
    endtask

    task automatic set_gains(logic [G_W-1:0] kp, logic [G_W-1:0] ki, logic [G_W-1:0] kd);
        drain_results();
        cfg_write(REG_KP, kp);
        cfg_write(REG_KI, ki);
        cfg_write(REG_KD, kd);
    endtask

    function automatic logic signed [E_W-1:0] rand_error();
        case ($urandom_range(0, 3))
            0: return E_W'($urandom_range(0, 511) - 256);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return E_W'($urandom);
        endcase
    endfunction

    function automatic logic [DT_W-1:0] rand_period();
        case ($urandom_range(0, 4))
            0: return DT_W'($urandom_range(1, 64));
            1: return DT_W'($urandom_range(256, 4096));
            2: begin
                case ($urandom_range(0, 2))
                    0: return 16'd0;
                    1: return 16'd1;
                    default: return 16'hffff;
                endcase
            end
            default: return DT_W'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic test_reset_state();
        send_item(CMD_STEP, 16'sh7fff, 16'd0);
        send_item(CMD_STEP, 16'sh8000, 16'hffff);
        send_item(CMD_STEP, 16'sd256, 16'd1);
        send_item(CMD_CLEAR, 16'sd0, 16'd1);
    endtask

    task automatic test_directed_cases();
        set_gains(16'h0100, 16'h0080, 16'h0040);
        send_item(CMD_STEP, 16'sd256, 16'd655);
        send_item(CMD_STEP, 16'sh8000, 16'd1);
        send_item(CMD_STEP, 16'sh7fff, 16'hffff);
        send_item(CMD_STEP, 16'sd0, 16'd0);
        send_item(CMD_STEP, -16'sd1, 16'd0);
        send_item(CMD_CLEAR, 16'sh7fff, 16'hffff);
        set_gains(16'hffff, 16'hffff, 16'hffff);
        send_item(CMD_STEP, 16'sh7fff, 16'd1);
        send_item(CMD_STEP, 16'sh7fff, 16'd1);
        send_item(CMD_STEP, 16'sh7fff, 16'd1);
        send_item(CMD_STEP, 16'sh8000, 16'd1);
        send_item(CMD_STEP, 16'sh8000, 16'd1);
        send_item(CMD_STEP, 16'sh8000, 16'd0);
        send_item(CMD_STEP, 16'sh8000, 16'hffff);
        send_item(CMD_CLEAR, 16'sh8000, 16'd0);
        send_item(CMD_STEP, 16'sh8000, 16'hffff);
    endtask

    task automatic test_register_index();
        set_gains(16'h0200, 16'h0100, 16'h0010);
        cfg_write(REG_UNUSED, 16'hffff);
        send_item(CMD_STEP, 16'sd1000, 16'd100);
        send_item(CMD_STEP, -16'sd500, 16'd100);
        send_item(CMD_CLEAR, 16'sd0, 16'd1);
    endtask

    task automatic test_random_phase(logic [G_W-1:0] kp, logic [G_W-1:0] ki, logic [G_W-1:0] kd,
                                     int count, bit quiet);
        set_gains(kp, ki, kd);
        no_idle = quiet;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain_results();
            if ($urandom_range(0, 19) == 0)
                send_item(CMD_CLEAR, E_W'($urandom), DT_W'($urandom));
            else
                send_item(CMD_STEP, rand_error(), rand_period());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_cases();
        test_register_index();
        test_random_phase(16'h0000, 16'h0000, 16'h0000, 120, 1'b0);
        test_random_phase(16'hffff, 16'hffff, 16'hffff, 270, 1'b0);
        test_random_phase(16'h0100, 16'h0020, 16'h0008, 270, 1'b1);
        test_random_phase(G_W'($urandom), G_W'($urandom), G_W'($urandom), 270, 1'b0);
        test_random_phase(16'hffff, 16'h0000, 16'hffff, 200, 1'b0);
        test_random_phase(16'h0000, 16'hffff, 16'h0000, 200, 1'b0);
        test_random_phase(G_W'($urandom), G_W'($urandom), G_W'($urandom), 270, 1'b0);
        test_random_phase(G_W'($urandom_range(0, 1023)), G_W'($urandom_range(0, 255)),
                          G_W'($urandom_range(0, 63)), 270, 1'b0);
        drain_results();
        repeat (RESULT_LATENCY) @(posedge i_clk);
        if (error_count == 0 && expected_outputs.size() == 0) begin
            $display("[discrete_pid_velocity_form] OK");
        end else begin
            $display("[discrete_pid_velocity_form] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/dpvf_pkg.sv
rtl/discrete_pid_velocity_form.sv
tb/testbench.sv
